[hdl/kmn_pkg.sv]
// Package for the k-means nearest-centre block: sizes, codes and payload types.
// Used by kmn_ctrl, kmn_datapath and kmeans_nearest_center; depends on nothing.
package kmn_pkg;

  localparam int unsigned MAX_CLUSTERS   = 16;
  localparam int unsigned MAX_FEATURES   = 64;
  localparam int unsigned VALUE_BITS     = 16;
  localparam int unsigned CLUSTER_BITS   = $clog2(MAX_CLUSTERS);
  localparam int unsigned FEATURE_BITS   = $clog2(MAX_FEATURES);
  localparam int unsigned STORE_DEPTH    = MAX_CLUSTERS * MAX_FEATURES;
  localparam int unsigned SUM_BITS       = 38;
  localparam int unsigned MAG_BITS       = VALUE_BITS + 1;
  localparam int unsigned SQ_BITS        = 2 * MAG_BITS;
  localparam int unsigned CCOUNT_BITS    = 5;
  localparam int unsigned FCOUNT_BITS    = 7;
  localparam int unsigned CFG_DATA_BITS  = 7;
  localparam int unsigned CFG_INDEX_BITS = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLUSTER_COUNT = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FEATURE_COUNT = 1'b1;

  // Item commands.
  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_FEATURE = 1'b1;

  typedef struct packed {
    logic                           command;
    logic [CLUSTER_BITS-1:0]        cluster_index;
    logic [FEATURE_BITS-1:0]        feature_index;
    logic signed [VALUE_BITS-1:0]   value;
    logic                           last;
  } item_t;

  typedef struct packed {
    logic [CLUSTER_BITS-1:0] label;
    logic                    status;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                    store;
    logic                    load_value;
    logic                    rd_en;
    logic [CLUSTER_BITS-1:0] rd_cluster;
    logic [FEATURE_BITS-1:0] rd_feature;
    logic                    clear_sums;
  } dp_cmd_t;

endpackage

[hdl/kmeans_nearest_center.sv]
// Top level of the k-means nearest-centre classifier: configuration registers and wiring.
// Depends on kmn_pkg, kmn_ctrl and kmn_datapath.
//
//   Channel   Handshake            Payload                 Notes
//   item      start_i / busy_o     item_i (item_t)         accepted when start_i and not busy_o
//   result    result_valid_o       result_o (result_t)     one-cycle strobe, cannot be held off
//   config    cfg_we_i             cfg_index_i, cfg_data_i written at once, no read-back
//
// A centre load never raises busy_o.
// A sample feature keeps busy_o high while the controller walks the active clusters
// through the single read port of the centre store and drains; a last one passes ST_DONE.
// A feature past the configured count raises busy_o only when it is marked last.
// Reset clears the sums and the controller; the centre store is not cleared.
module kmeans_nearest_center (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  kmn_pkg::item_t                        item_i,
  output logic                                  result_valid_o,
  output kmn_pkg::result_t                      result_o,
  input  logic                                  cfg_we_i,
  input  logic [kmn_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [kmn_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  logic [kmn_pkg::CCOUNT_BITS-1:0]  cluster_count_q;
  logic [kmn_pkg::FCOUNT_BITS-1:0]  feature_count_q;
  kmn_pkg::dp_cmd_t                 dp_cmd;
  logic [kmn_pkg::CLUSTER_BITS-1:0] best_label;
  logic                             status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_count_q <= kmn_pkg::CCOUNT_BITS'(16);
      feature_count_q <= kmn_pkg::FCOUNT_BITS'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kmn_pkg::CFG_CLUSTER_COUNT: cluster_count_q <= cfg_data_i[kmn_pkg::CCOUNT_BITS-1:0];
        kmn_pkg::CFG_FEATURE_COUNT: feature_count_q <= cfg_data_i[kmn_pkg::FCOUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  kmn_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .item_i          (item_i),
    .cluster_count_i (cluster_count_q),
    .feature_count_i (feature_count_q),
    .busy_o          (busy_o),
    .cmd_o           (dp_cmd),
    .result_valid_o  (result_valid_o),
    .status_o        (status)
  );

  kmn_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cmd_i   (dp_cmd),
    .label_o (best_label)
  );

  // A mismatched sample reports label zero.
  assign result_o.label  = status ? '0 : best_label;
  assign result_o.status = status;

endmodule

[hdl/kmn_datapath.sv]
// Datapath: centre store, squared-difference pipeline, distance sums and argmin tracker.
// Depends on kmn_pkg; driven by kmn_ctrl through kmn_pkg::dp_cmd_t.
module kmn_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kmn_pkg::item_t                      item_i,
  input  kmn_pkg::dp_cmd_t                    cmd_i,
  output logic [kmn_pkg::CLUSTER_BITS-1:0]    label_o
);

  logic signed [kmn_pkg::VALUE_BITS-1:0] store_mem [kmn_pkg::STORE_DEPTH];
  logic signed [kmn_pkg::VALUE_BITS-1:0] mem_q;
  logic signed [kmn_pkg::VALUE_BITS-1:0] value_q;

  logic                                  v1_q, v2_q;
  logic [kmn_pkg::CLUSTER_BITS-1:0]      k1_q, k2_q;
  logic [kmn_pkg::SQ_BITS-1:0]           sq_q;

  logic [kmn_pkg::SUM_BITS-1:0]          sums_q [kmn_pkg::MAX_CLUSTERS];
  logic [kmn_pkg::SUM_BITS-1:0]          best_sum_q;
  logic [kmn_pkg::CLUSTER_BITS-1:0]      best_idx_q;

  logic signed [kmn_pkg::MAG_BITS-1:0]   diff;
  logic [kmn_pkg::MAG_BITS-1:0]          mag;
  logic [kmn_pkg::SUM_BITS:0]            sum_wide;
  logic [kmn_pkg::SUM_BITS-1:0]          sum_new;

  // Centre store: one write port for loads, one registered read port for the walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      store_mem[{item_i.cluster_index, item_i.feature_index}] <= item_i.value;
    end
    if (cmd_i.rd_en) begin
      mem_q <= store_mem[{cmd_i.rd_cluster, cmd_i.rd_feature}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_value) begin
      value_q <= item_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      k1_q <= '0;
      k2_q <= '0;
    end else begin
      v1_q <= cmd_i.rd_en;
      k1_q <= cmd_i.rd_cluster;
      v2_q <= v1_q;
      k2_q <= k1_q;
    end
  end

  // The difference of two values is exact in one extra bit; its magnitude then fits unsigned.
  always_comb begin
    diff = {value_q[kmn_pkg::VALUE_BITS-1], value_q} - {mem_q[kmn_pkg::VALUE_BITS-1], mem_q};
    mag  = diff[kmn_pkg::MAG_BITS-1] ? kmn_pkg::MAG_BITS'(-diff) : kmn_pkg::MAG_BITS'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      sq_q <= mag * mag;
    end
  end

  always_comb begin
    sum_wide = {1'b0, sums_q[k2_q]} + {{(kmn_pkg::SUM_BITS + 1 - kmn_pkg::SQ_BITS){1'b0}}, sq_q};
    sum_new  = sum_wide[kmn_pkg::SUM_BITS] ? '1 : sum_wide[kmn_pkg::SUM_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kmn_pkg::MAX_CLUSTERS; i++) begin
        sums_q[i] <= '0;
      end
    end else if (cmd_i.clear_sums) begin
      for (int i = 0; i < kmn_pkg::MAX_CLUSTERS; i++) begin
        sums_q[i] <= '0;
      end
    end else if (v2_q) begin
      sums_q[k2_q] <= sum_new;
    end
  end

  // Clusters arrive in ascending order, so a strict compare keeps the lowest index on ties.
  always_ff @(posedge clk_i) begin
    if (v2_q && ((k2_q == '0) || (sum_new < best_sum_q))) begin
      best_sum_q <= sum_new;
      best_idx_q <= k2_q;
    end
  end

  assign label_o = best_idx_q;

  a_stage2_follows_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (k2_q == $past(k1_q)) && $past(v1_q))
    else $error("accumulate stage active without a preceding square stage");

endmodule

[hdl/kmn_ctrl.sv]
// Controller: accepts items, counts features and sequences the walk over active clusters.
// Depends on kmn_pkg; commands kmn_datapath through kmn_pkg::dp_cmd_t.
module kmn_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  kmn_pkg::item_t                       item_i,
  input  logic [kmn_pkg::CCOUNT_BITS-1:0]      cluster_count_i,
  input  logic [kmn_pkg::FCOUNT_BITS-1:0]      feature_count_i,
  output logic                                 busy_o,
  output kmn_pkg::dp_cmd_t                     cmd_o,
  output logic                                 result_valid_o,
  output logic                                 status_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [kmn_pkg::CLUSTER_BITS-1:0]  k_q, k_d;
  logic [kmn_pkg::FEATURE_BITS-1:0]  feat_q, feat_d;
  logic [kmn_pkg::FCOUNT_BITS-1:0]   fs_q, fs_d;
  logic                              drain_q, drain_d;
  logic                              last_q, last_d;
  logic                              mismatch_q, mismatch_d;

  logic [kmn_pkg::CCOUNT_BITS-1:0]   nc;
  logic [kmn_pkg::FCOUNT_BITS-1:0]   nf;
  logic [kmn_pkg::FCOUNT_BITS-1:0]   fs_next;
  logic                              accept;
  logic                              feature_acc;
  logic                              walk;

  always_comb begin
    if (cluster_count_i == '0) begin
      nc = kmn_pkg::CCOUNT_BITS'(1);
    end else if (cluster_count_i > kmn_pkg::CCOUNT_BITS'(kmn_pkg::MAX_CLUSTERS)) begin
      nc = kmn_pkg::CCOUNT_BITS'(kmn_pkg::MAX_CLUSTERS);
    end else begin
      nc = cluster_count_i;
    end
    if (feature_count_i == '0) begin
      nf = kmn_pkg::FCOUNT_BITS'(1);
    end else if (feature_count_i > kmn_pkg::FCOUNT_BITS'(kmn_pkg::MAX_FEATURES)) begin
      nf = kmn_pkg::FCOUNT_BITS'(kmn_pkg::MAX_FEATURES);
    end else begin
      nf = feature_count_i;
    end
  end

  assign accept      = start_i && (state_q == ST_IDLE);
  assign feature_acc = accept && (item_i.command == kmn_pkg::CMD_FEATURE);
  // Features past the configured count add nothing; the count stops one above it.
  assign walk        = fs_q < nf;
  assign fs_next     = (fs_q <= nf) ? fs_q + kmn_pkg::FCOUNT_BITS'(1) : fs_q;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    feat_d     = feat_q;
    fs_d       = fs_q;
    drain_d    = drain_q;
    last_d     = last_q;
    mismatch_d = mismatch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (feature_acc) begin
          fs_d       = fs_next;
          last_d     = item_i.last;
          mismatch_d = (fs_next != nf);
          feat_d     = fs_q[kmn_pkg::FEATURE_BITS-1:0];
          k_d        = '0;
          if (walk) begin
            state_d = ST_WALK;
          end else if (item_i.last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if ({1'b0, k_q} == nc - kmn_pkg::CCOUNT_BITS'(1)) begin
          state_d = ST_DRAIN;
          drain_d = 1'b0;
        end else begin
          k_d = k_q + kmn_pkg::CLUSTER_BITS'(1);
        end
      end
      ST_DRAIN: begin
        // The drain lets the last cluster pass the square and accumulate stages.
        if (drain_q) begin
          state_d = last_q ? ST_DONE : ST_IDLE;
        end else begin
          drain_d = 1'b1;
        end
      end
      ST_DONE: begin
        fs_d    = '0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      k_q        <= '0;
      feat_q     <= '0;
      fs_q       <= '0;
      drain_q    <= 1'b0;
      last_q     <= 1'b0;
      mismatch_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      feat_q     <= feat_d;
      fs_q       <= fs_d;
      drain_q    <= drain_d;
      last_q     <= last_d;
      mismatch_q <= mismatch_d;
    end
  end

  always_comb begin
    cmd_o.store      = accept && (item_i.command == kmn_pkg::CMD_STORE);
    cmd_o.load_value = feature_acc;
    cmd_o.rd_en      = (state_q == ST_WALK);
    cmd_o.rd_cluster = k_q;
    cmd_o.rd_feature = feat_q;
    cmd_o.clear_sums = (state_q == ST_DONE);
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_DONE);
  assign status_o       = mismatch_q;

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_status_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (mismatch_q == (fs_q != nf)))
    else $error("status disagrees with the feature count of the sample");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ({1'b0, k_q} < nc))
    else $error("cluster walk passed the active cluster count");

endmodule

[bench/kmeans_nearest_center_test.sv]
// Self-checking testbench for kmeans_nearest_center: centre loads and sample streams
// with random gaps, checked against a cycle-free model of the classifier.
// Depends on kmn_pkg and kmeans_nearest_center.
module kmeans_nearest_center_test;

  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned TOTAL_ITEMS    = 1200;
  localparam logic STATUS_OK             = 1'b0;
  localparam logic STATUS_COUNT_MISMATCH = 1'b1;
  localparam logic [kmn_pkg::SUM_BITS-1:0] SUM_MAX = '1;

  typedef struct {
    kmn_pkg::item_t item;
    int unsigned    gap;
  } queued_item_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start_i = 1'b0;
  logic                               busy_o;
  kmn_pkg::item_t                     item_i = '0;
  logic                               result_valid_o;
  kmn_pkg::result_t                   result_o;
  logic                               cfg_we_i = 1'b0;
  logic [kmn_pkg::CFG_INDEX_BITS-1:0] cfg_index_i = kmn_pkg::CFG_CLUSTER_COUNT;
  logic [kmn_pkg::CFG_DATA_BITS-1:0]  cfg_data_i = '0;

  // Stimulus side.
  queued_item_t item_q[$];
  logic [kmn_pkg::VALUE_BITS-1:0] gen_centre [kmn_pkg::MAX_CLUSTERS][kmn_pkg::MAX_FEATURES];
  bit                             gen_loaded [kmn_pkg::MAX_CLUSTERS][kmn_pkg::MAX_FEATURES];
  bit                             burst_mode;
  int unsigned                    items_issued;
  int unsigned                    gap_left;
  bit                             gap_armed;

  // Model of the block and expected labels.
  logic [kmn_pkg::VALUE_BITS-1:0]  centre_mem [kmn_pkg::MAX_CLUSTERS][kmn_pkg::MAX_FEATURES];
  logic [kmn_pkg::SUM_BITS-1:0]    dist_sum [kmn_pkg::MAX_CLUSTERS];
  int unsigned                     seen_count;
  logic [kmn_pkg::CCOUNT_BITS-1:0] model_clusters = 5'd16;
  logic [kmn_pkg::FCOUNT_BITS-1:0] model_features = 7'd64;
  kmn_pkg::result_t                label_q[$];
  int unsigned                     mismatches;
  int unsigned                     quiet_cycles;

  kmeans_nearest_center u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned effective_count(input int unsigned v, input int unsigned hi);
    if (v == 0) begin
      return 1;
    end
    return (v > hi) ? hi : v;
  endfunction

  task automatic classify_item(input kmn_pkg::item_t it);
    int unsigned nc;
    int unsigned nf;
    int unsigned best;
    logic signed [kmn_pkg::VALUE_BITS:0] diff;
    logic [kmn_pkg::MAG_BITS-1:0] mag;
    logic [kmn_pkg::SUM_BITS:0] wide_mag;
    logic [kmn_pkg::SUM_BITS:0] acc;
    kmn_pkg::result_t res;
    nc = effective_count(model_clusters, kmn_pkg::MAX_CLUSTERS);
    nf = effective_count(model_features, kmn_pkg::MAX_FEATURES);
    if (it.command == kmn_pkg::CMD_STORE) begin
      centre_mem[it.cluster_index][it.feature_index] = it.value;
    end else begin
      // Features past the configured count are counted but add nothing.
      if (seen_count < nf) begin
        for (int k = 0; k < nc; k++) begin
          diff = $signed({it.value[kmn_pkg::VALUE_BITS-1], it.value})
               - $signed({centre_mem[k][seen_count][kmn_pkg::VALUE_BITS-1],
                          centre_mem[k][seen_count]});
          mag = diff[kmn_pkg::VALUE_BITS] ? kmn_pkg::MAG_BITS'(-diff)
                                          : kmn_pkg::MAG_BITS'(diff);
          wide_mag = mag;
          acc = {1'b0, dist_sum[k]} + wide_mag * wide_mag;
          dist_sum[k] = (acc > {1'b0, SUM_MAX}) ? SUM_MAX : acc[kmn_pkg::SUM_BITS-1:0];
        end
      end
      if (seen_count <= nf) begin
        seen_count++;
      end
      if (it.last) begin
        if (seen_count != nf) begin
          res.label  = '0;
          res.status = STATUS_COUNT_MISMATCH;
        end else begin
          best = 0;
          for (int k = 1; k < nc; k++) begin
            if (dist_sum[k] < dist_sum[best]) begin
              best = k;
            end
          end
          res.label  = kmn_pkg::CLUSTER_BITS'(best);
          res.status = STATUS_OK;
        end
        label_q.push_back(res);
        foreach (dist_sum[k]) begin
          dist_sum[k] = '0;
        end
        seen_count = 0;
      end
    end
  endtask

  // Driver: presents queued items, each after its own idle gap.
  always @(posedge clk_i) begin : drive
    logic holding;
    holding = start_i && busy_o;
    if (rst_ni && !holding) begin
      if (item_q.size() == 0) begin
        start_i <= 1'b0;
      end else begin
        if (!gap_armed) begin
          gap_left  = item_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left == 0) begin
          item_i  <= item_q[0].item;
          start_i <= 1'b1;
          void'(item_q.pop_front());
          gap_armed = 1'b0;
        end else begin
          start_i <= 1'b0;
          gap_left--;
        end
      end
    end
  end

  // Monitor: checks results first, then predicts from the item taken at this edge.
  always @(posedge clk_i) begin : observe
    kmn_pkg::result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (label_q.size() == 0) begin
          $error("unexpected result: label %0d status %0d", result_o.label, result_o.status);
          mismatches++;
        end else begin
          want = label_q.pop_front();
          if (result_o.label !== want.label) begin
            $error("label: expected %0d, actual %0d", want.label, result_o.label);
            mismatches++;
          end
          if (result_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result_o.status);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_o) begin
        classify_item(item_i);
      end
      if (result_valid_o || (start_i && !busy_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic cmd, input int unsigned ci, input int unsigned fi,
                            input logic [kmn_pkg::VALUE_BITS-1:0] val, input logic last);
    queued_item_t q;
    q.item.command       = cmd;
    q.item.cluster_index = kmn_pkg::CLUSTER_BITS'(ci);
    q.item.feature_index = kmn_pkg::FEATURE_BITS'(fi);
    q.item.value         = val;
    q.item.last          = last;
    q.gap = burst_mode ? 0 : $urandom_range(0, 15);
    item_q.push_back(q);
    items_issued++;
    if (cmd == kmn_pkg::CMD_STORE) begin
      gen_centre[ci][fi] = val;
      gen_loaded[ci][fi] = 1'b1;
    end
  endtask

  function automatic logic [kmn_pkg::VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_quiet();
    do begin
      @(negedge clk_i);
    end while (item_q.size() != 0 || start_i || busy_o || label_q.size() != 0);
    // Centre loads and surplus features raise no result, so let the block drain.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_registers(input logic [kmn_pkg::CFG_DATA_BITS-1:0] clusters_data,
                                 input logic [kmn_pkg::CFG_DATA_BITS-1:0] features_data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= kmn_pkg::CFG_CLUSTER_COUNT;
    cfg_data_i  <= clusters_data;
    model_clusters = clusters_data[kmn_pkg::CCOUNT_BITS-1:0];
    @(posedge clk_i);
    cfg_index_i <= kmn_pkg::CFG_FEATURE_COUNT;
    cfg_data_i  <= features_data;
    model_features = features_data[kmn_pkg::FCOUNT_BITS-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One sample: mostly the configured length, sometimes short or long, with the odd
  // centre rewrite slipped in between features.
  task automatic queue_sample(input int unsigned nc, input int unsigned nf);
    int unsigned len;
    int unsigned target;
    int unsigned shape;
    logic [kmn_pkg::VALUE_BITS-1:0] v;
    shape = $urandom_range(0, 9);
    if (shape == 0 && nf > 1) begin
      len = $urandom_range(1, nf - 1);
    end else if (shape == 1) begin
      len = nf + $urandom_range(1, 3);
    end else begin
      len = nf;
    end
    target = $urandom_range(0, nc - 1);
    for (int p = 0; p < len; p++) begin
      if ($urandom_range(0, 19) == 0) begin
        queue_item(kmn_pkg::CMD_STORE, $urandom_range(0, 15), $urandom_range(0, 63),
                   pick_value(), 1'($urandom_range(0, 1)));
      end
      if (p < nf && $urandom_range(0, 3) != 0) begin
        v = gen_centre[target][p] + 16'($urandom_range(0, 511)) - 16'd256;
      end else begin
        v = 16'($urandom);
      end
      queue_item(kmn_pkg::CMD_FEATURE, $urandom_range(0, 15), $urandom_range(0, 63), v,
                 p == len - 1);
    end
  endtask

  task automatic run_phase(input logic [kmn_pkg::CFG_DATA_BITS-1:0] clusters_data,
                           input logic [kmn_pkg::CFG_DATA_BITS-1:0] features_data);
    int unsigned nc;
    int unsigned nf;
    int unsigned samples;
    nc = effective_count(clusters_data[kmn_pkg::CCOUNT_BITS-1:0], kmn_pkg::MAX_CLUSTERS);
    nf = effective_count(features_data, kmn_pkg::MAX_FEATURES);
    wait_quiet();
    write_registers(clusters_data, features_data);
    burst_mode = ($urandom_range(0, 3) == 0);
    // Every element a sample can reach must be written before it is read.
    for (int k = 0; k < nc; k++) begin
      for (int p = 0; p < nf; p++) begin
        if (!gen_loaded[k][p] || $urandom_range(0, 7) == 0) begin
          queue_item(kmn_pkg::CMD_STORE, k, p, pick_value(), 1'($urandom_range(0, 1)));
        end
      end
    end
    samples = (nf <= 8) ? $urandom_range(4, 12) : $urandom_range(2, 3);
    repeat (samples) queue_sample(nc, nf);
  endtask

  initial begin : stimulus
    logic [kmn_pkg::CCOUNT_BITS-1:0] pick_clusters;
    logic [kmn_pkg::CFG_DATA_BITS-1:0] pick_features;
    foreach (dist_sum[k]) begin
      dist_sum[k] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: three clusters of two features.
    write_registers(7'd3, 7'd2);
    burst_mode = 1'b0;
    queue_item(kmn_pkg::CMD_STORE, 0, 0, 16'h7FFF, 1'b0);
    queue_item(kmn_pkg::CMD_STORE, 0, 1, 16'h8000, 1'b1);   // last is ignored on a load
    queue_item(kmn_pkg::CMD_STORE, 1, 0, 16'h0000, 1'b0);
    queue_item(kmn_pkg::CMD_STORE, 1, 1, 16'h0000, 1'b0);
    queue_item(kmn_pkg::CMD_STORE, 2, 0, 16'h0000, 1'b0);
    queue_item(kmn_pkg::CMD_STORE, 2, 1, 16'h0000, 1'b0);
    queue_item(kmn_pkg::CMD_STORE, 15, 63, 16'h1234, 1'b0);
    // Exact hit on cluster 0.
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h7FFF, 1'b0);
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h8000, 1'b1);
    // Clusters 1 and 2 tie; the lower index wins.
    queue_item(kmn_pkg::CMD_FEATURE, 15, 63, 16'h0000, 1'b0);
    queue_item(kmn_pkg::CMD_FEATURE, 15, 63, 16'h0000, 1'b1);
    // Largest possible differences against cluster 0.
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h8000, 1'b0);
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h7FFF, 1'b1);
    // Too few features.
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h0005, 1'b1);
    // Too many features, once just over and once past the saturated count.
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h0001, 1'b0);
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h0002, 1'b0);
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h0003, 1'b1);
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h0001, 1'b0);
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h0002, 1'b0);
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h0003, 1'b0);
    queue_item(kmn_pkg::CMD_FEATURE, 0, 0, 16'h0004, 1'b1);

    // Register extremes, including zero and out-of-range values.
    run_phase(7'd16, 7'd3);
    run_phase(7'd1, 7'd64);
    run_phase(7'd0, 7'd0);
    run_phase(7'd31, 7'd5);
    run_phase(7'd2, 7'd127);

    while (items_issued < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0: pick_clusters = 5'd16;
        1: pick_clusters = 5'd0;
        2: pick_clusters = 5'($urandom_range(17, 31));
        default: pick_clusters = 5'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0: pick_features = 7'd64;
        1: pick_features = 7'd0;
        2: pick_features = 7'($urandom_range(65, 127));
        default: pick_features = 7'($urandom_range(1, 8));
      endcase
      // Keep the centre loads of one setting modest.
      if (effective_count(pick_clusters, kmn_pkg::MAX_CLUSTERS) *
          effective_count(pick_features, kmn_pkg::MAX_FEATURES) > 160) begin
        pick_features = 7'($urandom_range(1, 8));
      end
      run_phase({2'($urandom), pick_clusters}, pick_features);
    end

    wait_quiet();
    if (mismatches == 0 && label_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
